@@ hdl/bsm_pkg.sv @@
// Shared types and constants of the bank switch mapper.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int OP_W       = 3;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int TGT_W      = 3;
  localparam int MEM_ADDR_W = 21;
  localparam int OFS_W      = 13;
  localparam int STEP_W     = 4;
  localparam int BANK_REG_COUNT = 8;
  localparam int BANK_IDX_W = 3;

  localparam logic [STEP_W-1:0] BANK_STEPS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM   = 2'd2;

  // Register decode key: {addr[15:13], addr[0]}
  localparam logic [3:0] REG_BANK_SEL   = 4'b1000;
  localparam logic [3:0] REG_BANK_DATA  = 4'b1001;
  localparam logic [3:0] REG_MIRROR     = 4'b1010;
  localparam logic [3:0] REG_RAM_PROT   = 4'b1011;
  localparam logic [3:0] REG_IRQ_LATCH  = 4'b1100;
  localparam logic [3:0] REG_IRQ_RELOAD = 4'b1101;
  localparam logic [3:0] REG_IRQ_DIS    = 4'b1110;
  localparam logic [3:0] REG_IRQ_EN     = 4'b1111;

  localparam logic [BANK_IDX_W-1:0] BANK_R6 = 3'd6;
  localparam logic [BANK_IDX_W-1:0] BANK_R7 = 3'd7;
  localparam logic [BANK_IDX_W-1:0] BANK_R2 = 3'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CPU_RD   = 3'd0,
    OP_CPU_WR   = 3'd1,
    OP_PPU_RD   = 3'd2,
    OP_PPU_WR   = 3'd3,
    OP_SCANLINE = 3'd4,
    OP_IRQ_CLR  = 3'd5
  } op_t;

  typedef enum logic [TGT_W-1:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4
  } tgt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

@@ hdl/bsm_ctrl.sv @@
// Controller state machine: accept, remainder steps, result commit.
`timescale 1ns / 1ps
module bsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output bsm_pkg::ctrl_cmd_t cmd,
  input  bsm_pkg::dp_status_t status
);
  import bsm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_room;

  assign out_room = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_room) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = out_room;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

@@ hdl/bsm_datapath.sv @@
// Datapath: mapper state, remainder unit, address build and result register.
`timescale 1ns / 1ps
module bsm_datapath #(
  parameter int PRG_RAM_BYTES = 8192
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [bsm_pkg::OP_W-1:0]         in_op,
  input  logic [bsm_pkg::ADDR_W-1:0]       in_addr,
  input  logic [bsm_pkg::DATA_W-1:0]       in_data,
  input  logic                             cfg_wr_en,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]        cfg_data,
  input  bsm_pkg::ctrl_cmd_t               cmd,
  output bsm_pkg::dp_status_t              status,
  output logic [23:0]                      out_data,
  output logic [bsm_pkg::TGT_W-1:0]        out_user
);
  import bsm_pkg::*;

  localparam int DIV_W  = OFS_W + 1;
  localparam int RAM_AW = $clog2(PRG_RAM_BYTES);

  // configuration
  logic [CFG_W-1:0] prg_count;
  logic [CFG_W-1:0] chr_count;
  logic             chr_ram;

  // mapper state
  logic [DATA_W-1:0] sel;
  logic [DATA_W-1:0] banks [BANK_REG_COUNT];
  logic              mirror;
  logic [1:0]        prot;
  logic [DATA_W-1:0] irq_reload;
  logic [DATA_W-1:0] irq_cnt;
  logic              irq_en;
  logic              irq_flag;

  // latched item
  logic [OP_W-1:0]   it_op;
  logic [ADDR_W-1:0] it_addr;
  logic [DATA_W-1:0] it_data;

  // remainder unit
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [OFS_W-1:0]  dvd;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W:0]    trial;
  logic              sub_mode;

  logic [CFG_W-1:0] pc_eff;
  logic [CFG_W-1:0] cc_eff;

  always_comb begin
    if (prg_count < 9'd2) pc_eff = 9'd2;
    else if (prg_count > 9'd256) pc_eff = 9'd256;
    else pc_eff = prg_count;
    if (chr_count < 9'd1) cc_eff = 9'd1;
    else if (chr_count > 9'd256) cc_eff = 9'd256;
    else cc_eff = chr_count;
  end

  // operand selection at accept
  logic [BANK_IDX_W-1:0] rd_idx;
  logic                  rd_mask;
  logic                  use_ofs;
  logic                  use_chr;
  logic                  in_two_kb;
  logic [DATA_W-1:0]     bank_rd;
  logic [DATA_W-1:0]     bank_val;

  assign in_two_kb = (in_addr[12] == sel[7]);

  always_comb begin
    rd_idx  = BANK_R6;
    rd_mask = 1'b0;
    use_ofs = 1'b0;
    use_chr = 1'b0;
    if ((in_op == OP_CPU_RD || in_op == OP_CPU_WR) && in_addr[15:13] == 3'b011) begin
      use_ofs = 1'b1;
    end else if (in_op == OP_PPU_RD || in_op == OP_PPU_WR) begin
      use_chr = 1'b1;
      if (in_two_kb) begin
        rd_idx  = {2'b00, in_addr[11]};
        rd_mask = 1'b1;
      end else begin
        rd_idx = BANK_R2 + {1'b0, in_addr[11:10]};
      end
    end else if (in_addr[14:13] == 2'b01) begin
      rd_idx = BANK_R7;
    end
  end

  assign bank_rd  = banks[rd_idx];
  assign bank_val = rd_mask ? (bank_rd & 8'hFE) : bank_rd;

  assign trial = {rem, dvd[OFS_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      it_op   <= in_op;
      it_addr <= in_addr;
      it_data <= in_data;
      cnt     <= BANK_STEPS;
      if (use_ofs) begin
        // RAM offset: subtract the RAM size while it fits, at most once per remainder step
        sub_mode <= 1'b1;
        rem      <= DIV_W'(in_addr[OFS_W-1:0]);
        dvs      <= DIV_W'(PRG_RAM_BYTES);
      end else begin
        sub_mode <= 1'b0;
        rem      <= '0;
        dvs      <= use_chr ? DIV_W'(cc_eff) : DIV_W'(pc_eff);
        dvd      <= {bank_val, {(OFS_W - DATA_W){1'b0}}};
      end
    end else if (cmd.step) begin
      if (sub_mode) begin
        if (rem >= dvs) rem <= rem - dvs;
      end else begin
        if (trial >= {1'b0, dvs}) rem <= DIV_W'(trial - {1'b0, dvs});
        else rem <= trial[DIV_W-1:0];
        dvd <= {dvd[OFS_W-2:0], 1'b0};
      end
      cnt <= cnt - 4'd1;
    end
  end

  assign status.div_last = (cnt == 4'd1);

  // address build from the latched item and the remainder
  logic              two_kb;
  logic [10:0]       chr_off;
  logic [18:0]       chr_raw;
  logic [18:0]       chr_size;
  logic [18:0]       chr_addr;
  logic [DATA_W-1:0] prg_bank;
  logic [1:0]        win;

  assign two_kb   = (it_addr[12] == sel[7]);
  assign chr_off  = two_kb ? it_addr[10:0] : {1'b0, it_addr[9:0]};
  assign chr_raw  = {1'b0, rem[7:0], 10'b0} + {8'b0, chr_off};
  assign chr_size = {cc_eff, 10'b0};
  assign chr_addr = (chr_raw >= chr_size) ? (chr_raw - chr_size) : chr_raw;
  assign win      = it_addr[14:13];

  always_comb begin
    if (win == 2'd3) prg_bank = 8'(pc_eff - 9'd1);
    else if ((win == 2'd0 && sel[6]) || (win == 2'd2 && !sel[6])) prg_bank = 8'(pc_eff - 9'd2);
    else prg_bank = rem[7:0];
  end

  // result and state update
  tgt_t                  tgt;
  logic [MEM_ADDR_W-1:0] maddr;
  logic                  wr;
  logic [DATA_W-1:0]     sel_next;
  logic                  bank_we;
  logic                  mirror_next;
  logic [1:0]            prot_next;
  logic [DATA_W-1:0]     irq_reload_next;
  logic [DATA_W-1:0]     irq_cnt_next;
  logic                  irq_en_next;
  logic                  irq_flag_next;
  logic [DATA_W-1:0]     tick_cnt;
  logic                  ram_on;
  logic                  ram_locked;
  logic                  in_ram;

  assign ram_on     = prot[1];
  assign ram_locked = prot[0];
  assign in_ram     = (it_addr[15:13] == 3'b011);
  assign tick_cnt   = (irq_cnt == 8'd0) ? irq_reload : (irq_cnt - 8'd1);

  always_comb begin
    tgt             = TGT_NONE;
    maddr           = '0;
    wr              = 1'b0;
    sel_next        = sel;
    bank_we         = 1'b0;
    mirror_next     = mirror;
    prot_next       = prot;
    irq_reload_next = irq_reload;
    irq_cnt_next    = irq_cnt;
    irq_en_next     = irq_en;
    irq_flag_next   = irq_flag;
    case (it_op)
      OP_CPU_RD: begin
        if (it_addr[15]) begin
          tgt   = TGT_PRG_ROM;
          maddr = {prg_bank, it_addr[12:0]};
        end else if (in_ram && ram_on) begin
          tgt   = TGT_PRG_RAM;
          maddr = {{(MEM_ADDR_W - RAM_AW){1'b0}}, rem[RAM_AW-1:0]};
        end
      end
      OP_CPU_WR: begin
        if (it_addr[15]) begin
          case ({it_addr[15:13], it_addr[0]})
            REG_BANK_SEL:   sel_next = it_data;
            REG_BANK_DATA:  bank_we = 1'b1;
            REG_MIRROR:     mirror_next = it_data[0];
            REG_RAM_PROT:   prot_next = it_data[7:6];
            REG_IRQ_LATCH:  irq_reload_next = it_data;
            REG_IRQ_RELOAD: irq_cnt_next = 8'd0;
            REG_IRQ_DIS: begin
              irq_en_next   = 1'b0;
              irq_flag_next = 1'b0;
            end
            REG_IRQ_EN:     irq_en_next = 1'b1;
            default:        irq_en_next = 1'b1;
          endcase
        end else if (in_ram && ram_on && !ram_locked) begin
          tgt   = TGT_PRG_RAM;
          maddr = {{(MEM_ADDR_W - RAM_AW){1'b0}}, rem[RAM_AW-1:0]};
          wr    = 1'b1;
        end
      end
      OP_PPU_RD: begin
        if (it_addr[15:13] == 3'b000) begin
          tgt   = chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
          maddr = {2'b00, chr_addr};
        end
      end
      OP_PPU_WR: begin
        if (it_addr[15:13] == 3'b000 && chr_ram) begin
          tgt   = TGT_CHR_RAM;
          maddr = {2'b00, chr_addr};
          wr    = 1'b1;
        end
      end
      OP_SCANLINE: begin
        irq_cnt_next = tick_cnt;
        if (tick_cnt == 8'd0 && irq_en) irq_flag_next = 1'b1;
      end
      OP_IRQ_CLR: begin
        irq_flag_next = 1'b0;
      end
      default: begin
        tgt = TGT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel        <= '0;
      mirror     <= 1'b0;
      prot       <= 2'b00;
      irq_reload <= '0;
      irq_cnt    <= '0;
      irq_en     <= 1'b0;
      irq_flag   <= 1'b0;
      for (int i = 0; i < BANK_REG_COUNT; i++) banks[i] <= '0;
    end else if (cmd.commit) begin
      sel        <= sel_next;
      mirror     <= mirror_next;
      prot       <= prot_next;
      irq_reload <= irq_reload_next;
      irq_cnt    <= irq_cnt_next;
      irq_en     <= irq_en_next;
      irq_flag   <= irq_flag_next;
      if (bank_we) banks[sel[BANK_IDX_W-1:0]] <= it_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {mirror_next, irq_flag_next, wr, maddr};
      out_user <= tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count <= 9'd2;
      chr_count <= 9'd8;
      chr_ram   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRG_COUNT: prg_count <= cfg_data;
        CFG_CHR_COUNT: chr_count <= cfg_data;
        CFG_CHR_RAM:   chr_ram <= cfg_data[0];
        default:       chr_ram <= chr_ram;
      endcase
    end
  end

endmodule

@@ hdl/bank_switch_mapper_with_scanline_irq_unit.sv @@
// Top level of the bank switch mapper with scanline interrupt counter.
// Each result passes through 8 remainder steps (one quotient bit of a bank number, or one
// subtraction of the RAM size) and a commit; a new transaction is accepted only after
// the previous one has been committed.
// Reset (rst, synchronous, active high): bank counts 2 and 8, pattern ROM, all mapper
// registers zero, interrupt off, no result pending.
`timescale 1ns / 1ps
module bank_switch_mapper_with_scanline_irq_unit #(
  parameter int PRG_RAM_BYTES = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  // input transaction
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // bus_address[15:0], write_data[23:16]
  input  logic [bsm_pkg::OP_W-1:0]      s_tuser,   // opcode[2:0]
  // result transaction
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // mem_address[20:0], mem_write[21],
                                                   // irq_line[22], mirror_horizontal[23]
  output logic [bsm_pkg::TGT_W-1:0]     m_tuser,   // mem_target[2:0]
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic [bsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]     cfg_data
);
  import bsm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence each transaction: accept, run the remainder steps, then commit the
  // state update and the result together once the output register has room.
  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Hold the mapper registers, reduce bank numbers modulo the bank counts and
  // build the physical address; the result register parts the two sides.
  bsm_datapath #(
    .PRG_RAM_BYTES (PRG_RAM_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_op     (s_tuser),
    .in_addr   (s_tdata[15:0]),
    .in_data   (s_tdata[23:16]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again while an item is in work");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !s_tready)
    else $error("remainder step while input is open");

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result committed over an untaken result");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");
`endif

endmodule

@@ tb/sv/tb_bank_switch_mapper_with_scanline_irq_unit.sv @@
// Self-checking testbench of the bank switch mapper with scanline interrupt counter.
`timescale 1ns / 1ps
module tb_bank_switch_mapper_with_scanline_irq_unit;
  import bsm_pkg::*;

  localparam int RAM_BYTES       = 8192;
  localparam int HOLD_OFF_CYCLES = 300;   // long output stall for the backpressure test
  localparam int SETTLE_CYCLES   = 20;    // above the latency of the block
  localparam int STALL_LIMIT     = 5000;  // cycles with no transaction before giving up
  localparam int REPORT_LIMIT    = 10;
  localparam int PRESET_COUNT    = 8;

  // Opcodes the block must ignore; the package enum stops at the interrupt clear.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    tgt_t                  target;
    logic [MEM_ADDR_W-1:0] address;
    logic                  mem_wr;
    logic                  irq;
    logic                  mirror;
  } bus_result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata   = '0;
  logic [OP_W-1:0]       s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;
  logic [TGT_W-1:0]      m_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  bank_switch_mapper_with_scanline_irq_unit #(
    .PRG_RAM_BYTES(RAM_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Mapper model: configuration, mapper registers and the derived bank windows.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] prg_banks_cfg;
  logic [CFG_W-1:0] chr_banks_cfg;
  logic             chr_ram_cfg;
  logic [7:0]       sel_q;
  logic [7:0]       bank_q [BANK_REG_COUNT];
  logic [7:0]       prg_win [4];
  logic [7:0]       chr_win [6];
  logic             mirror_q;
  logic [1:0]       ram_ctl_q;   // bit 1 RAM enabled, bit 0 write protected
  logic [7:0]       irq_latch_q;
  logic [7:0]       irq_cnt_q;
  logic             irq_en_q;
  logic             irq_pend_q;

  bus_result_t expected_bus_results [$];

  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int hold_req         = 0;
  int hold_ack         = 0;
  int hold_left        = 0;
  int stall_cycles     = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int mismatch_count   = 0;
  int settings_applied = 0;

  // Clamp the pattern bank count the way the block does.
  function automatic int unsigned chr_banks_eff();
    if (chr_banks_cfg < 1) return 1;
    if (chr_banks_cfg > 256) return 256;
    return chr_banks_cfg;
  endfunction

  // Recompute the bank number of every program and pattern window.
  function automatic void remap_windows();
    int unsigned pc;
    int unsigned cc;
    logic [7:0]  two_a;
    logic [7:0]  two_b;
    pc = prg_banks_cfg;
    if (pc < 2) pc = 2;
    else if (pc > 256) pc = 256;
    cc = chr_banks_eff();
    two_a = 8'((bank_q[0] & 8'hFE) % cc);
    two_b = 8'((bank_q[1] & 8'hFE) % cc);
    // Select bit 6 moves the fixed second-last bank between windows 0 and 2.
    if (!sel_q[6]) begin
      prg_win[0] = 8'(bank_q[BANK_R6] % pc);
      prg_win[2] = 8'(pc - 2);
    end else begin
      prg_win[0] = 8'(pc - 2);
      prg_win[2] = 8'(bank_q[BANK_R6] % pc);
    end
    prg_win[1] = 8'(bank_q[BANK_R7] % pc);
    prg_win[3] = 8'(pc - 1);
    // Select bit 7 swaps the 2KB and 1KB halves of pattern space.
    if (!sel_q[7]) begin
      chr_win[0] = two_a;
      chr_win[1] = two_b;
      for (int i = 0; i < 4; i++) chr_win[2 + i] = 8'(bank_q[BANK_R2 + i] % cc);
    end else begin
      for (int i = 0; i < 4; i++) chr_win[i] = 8'(bank_q[BANK_R2 + i] % cc);
      chr_win[4] = two_a;
      chr_win[5] = two_b;
    end
  endfunction

  function automatic void reset_model();
    prg_banks_cfg = 9'd2;
    chr_banks_cfg = 9'd8;
    chr_ram_cfg   = 1'b0;
    sel_q         = '0;
    for (int i = 0; i < BANK_REG_COUNT; i++) bank_q[i] = '0;
    mirror_q      = 1'b0;
    ram_ctl_q     = '0;
    irq_latch_q   = '0;
    irq_cnt_q     = '0;
    irq_en_q      = 1'b0;
    irq_pend_q    = 1'b0;
    remap_windows();
  endfunction

  // Physical pattern address of a PPU address below 0x2000, wrapped once.
  function automatic logic [MEM_ADDR_W-1:0] chr_phys(input logic [ADDR_W-1:0] a);
    int unsigned slot;
    int unsigned offs;
    int unsigned addr;
    int unsigned size;
    if (!sel_q[7]) begin
      if (a < 16'h1000) begin
        slot = a >> 11;
        offs = a & 16'h07FF;
      end else begin
        slot = 2 + ((a - 16'h1000) >> 10);
        offs = a & 16'h03FF;
      end
    end else begin
      if (a < 16'h1000) begin
        slot = a >> 10;
        offs = a & 16'h03FF;
      end else begin
        slot = 4 + ((a - 16'h1000) >> 11);
        offs = a & 16'h07FF;
      end
    end
    size = chr_banks_eff() * 1024;
    addr = 32'(chr_win[slot]) * 1024 + offs;
    if (addr >= size) addr = addr - size;
    return MEM_ADDR_W'(addr);
  endfunction

  // Advance the model by one bus transaction and return the result it produces.
  function automatic bus_result_t map_access(input logic [OP_W-1:0]   op,
                                             input logic [ADDR_W-1:0] a,
                                             input logic [DATA_W-1:0] d);
    bus_result_t res;
    res = '{target: TGT_NONE, address: '0, mem_wr: 1'b0, irq: 1'b0, mirror: 1'b0};
    case (op)
      OP_CPU_RD: begin
        if (a >= 16'h8000) begin
          res.target  = TGT_PRG_ROM;
          res.address = {prg_win[a[14:13]], a[12:0]};
        end else if (a >= 16'h6000 && ram_ctl_q[1]) begin
          res.target  = TGT_PRG_RAM;
          res.address = MEM_ADDR_W'((a - 16'h6000) % RAM_BYTES);
        end
      end
      OP_CPU_WR: begin
        if (a >= 16'h8000) begin
          case ({a[15:13], a[0]})
            REG_BANK_SEL: begin
              sel_q = d;
              remap_windows();
            end
            REG_BANK_DATA: begin
              bank_q[sel_q[2:0]] = d;
              remap_windows();
            end
            REG_MIRROR:     mirror_q    = d[0];
            REG_RAM_PROT:   ram_ctl_q   = d[7:6];
            REG_IRQ_LATCH:  irq_latch_q = d;
            REG_IRQ_RELOAD: irq_cnt_q   = '0;
            REG_IRQ_DIS: begin
              irq_en_q   = 1'b0;
              irq_pend_q = 1'b0;
            end
            default:        irq_en_q    = 1'b1;
          endcase
        end else if (a >= 16'h6000 && ram_ctl_q[1] && !ram_ctl_q[0]) begin
          res.target  = TGT_PRG_RAM;
          res.address = MEM_ADDR_W'((a - 16'h6000) % RAM_BYTES);
          res.mem_wr  = 1'b1;
        end
      end
      OP_PPU_RD: begin
        if (a < 16'h2000) begin
          res.target  = chr_ram_cfg ? TGT_CHR_RAM : TGT_CHR_ROM;
          res.address = chr_phys(a);
        end
      end
      OP_PPU_WR: begin
        if (a < 16'h2000 && chr_ram_cfg) begin
          res.target  = TGT_CHR_RAM;
          res.address = chr_phys(a);
          res.mem_wr  = 1'b1;
        end
      end
      OP_SCANLINE: begin
        // A zero counter reloads, so a zero reload value fires on every tick.
        if (irq_cnt_q == 0) irq_cnt_q = irq_latch_q;
        else irq_cnt_q = irq_cnt_q - 8'd1;
        if (irq_cnt_q == 0 && irq_en_q) irq_pend_q = 1'b1;
      end
      OP_IRQ_CLR: irq_pend_q = 1'b0;
      default: ;
    endcase
    res.irq    = irq_pend_q;
    res.mirror = mirror_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long hold-off on request, result checking.
  // ---------------------------------------------------------------------------

  // Drive tready; a new hold request starts a counted stall that overrides the
  // random pattern until it runs out.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.target  = tgt_t'(m_tuser);
      got.address = m_tdata[MEM_ADDR_W-1:0];
      got.mem_wr  = m_tdata[21];
      got.irq     = m_tdata[22];
      got.mirror  = m_tdata[23];
      if (expected_bus_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("%0t: result with nothing expected: target %0d addr %h", $time,
                   got.target, got.address);
        mismatch_count++;
      end else begin
        want = expected_bus_results.pop_front();
        results_checked++;
        if (got.target !== want.target || got.address !== want.address ||
            got.mem_wr !== want.mem_wr || got.irq !== want.irq ||
            got.mirror !== want.mirror) begin
          if (mismatch_count < REPORT_LIMIT)
            $display({"%0t: mismatch expected tgt %0d addr %h wr %b irq %b mir %b,",
                      " got tgt %0d addr %h wr %b irq %b mir %b"},
                     $time, want.target, want.address, want.mem_wr, want.irq, want.mirror,
                     got.target, got.address, got.mem_wr, got.irq, got.mirror);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: sending, settling and configuration.
  // ---------------------------------------------------------------------------

  // Offer one bus transaction after a random gap; predict it once accepted.
  task automatic send_item(input logic [OP_W-1:0]   op,
                           input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, addr};
    do @(posedge clk); while (!s_tready);
    expected_bus_results.push_back(map_access(op, addr, data));
    items_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bus_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Write all three configuration registers on consecutive cycles while idle.
  task automatic apply_setting(input logic [CFG_W-1:0] prg_count,
                               input logic [CFG_W-1:0] chr_count,
                               input logic             chr_ram);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PRG_COUNT;
    cfg_data  <= prg_count;
    @(posedge clk);
    cfg_index <= CFG_CHR_COUNT;
    cfg_data  <= chr_count;
    @(posedge clk);
    cfg_index <= CFG_CHR_RAM;
    cfg_data  <= {8'd0, chr_ram};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prg_banks_cfg = prg_count;
    chr_banks_cfg = chr_count;
    chr_ram_cfg   = chr_ram;
    remap_windows();
    settings_applied++;
  endtask

  task automatic apply_preset(input int idx);
    case (idx)
      0:       apply_setting(9'd2,   9'd8,   1'b0);  // reset values
      1:       apply_setting(9'd256, 9'd256, 1'b1);  // largest legal cartridge
      2:       apply_setting(9'd2,   9'd1,   1'b1);  // smallest legal cartridge
      3:       apply_setting(9'd0,   9'd0,   1'b0);  // counts below range clamp up
      4:       apply_setting(9'd511, 9'd511, 1'b1);  // counts above range clamp down
      5:       apply_setting(9'd3,   9'd5,   1'b0);  // odd counts, pattern wrap
      6:       apply_setting(9'd64,  9'd128, 1'b1);
      default: apply_setting(9'($urandom), 9'($urandom), 1'($urandom));
    endcase
  endtask

  // One random piece of traffic: mostly well-formed programming and accesses,
  // the rest fully random noise over every opcode, address and data bit.
  task automatic send_mapper_traffic();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // bank select followed by bank data, through random register mirrors
      send_item(OP_CPU_WR, 16'h8000 | (16'($urandom) & 16'h1FFE), 8'($urandom));
      send_item(OP_CPU_WR, 16'h8001 | (16'($urandom) & 16'h1FFE), 8'($urandom));
    end else if (kind < 16) begin
      // interrupt setup with a small reload value so ticks reach zero
      send_item(OP_CPU_WR, 16'hC000, 8'($urandom_range(0, 6)));
      send_item(OP_CPU_WR, 16'hC001, 8'($urandom));
      send_item(OP_CPU_WR, $urandom_range(0, 3) != 0 ? 16'hE001 : 16'hE000, 8'($urandom));
    end else if (kind < 22) begin
      send_item(OP_CPU_WR, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
    end else if (kind < 40) begin
      send_item(OP_CPU_RD, 16'($urandom_range(16'h6000, 16'hFFFF)), 8'($urandom));
    end else if (kind < 48) begin
      send_item(OP_CPU_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
    end else if (kind < 51) begin
      send_item(OP_CPU_WR, 16'hA001, 8'($urandom));
    end else if (kind < 70) begin
      send_item($urandom_range(0, 1) ? OP_PPU_RD : OP_PPU_WR,
                16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
    end else if (kind < 84) begin
      send_item(OP_SCANLINE, 16'($urandom), 8'($urandom));
    end else if (kind < 87) begin
      send_item(OP_IRQ_CLR, 16'($urandom), 8'($urandom));
    end else begin
      send_item(3'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Windows and unmapped cases straight after reset.
  task automatic test_reset_state();
    send_item(OP_CPU_RD,  16'h8000, 8'h00);
    send_item(OP_CPU_RD,  16'hFFFF, 8'hFF);  // fixed last bank
    send_item(OP_CPU_RD,  16'h0000, 8'h00);  // low CPU address, no target
    send_item(OP_CPU_RD,  16'h6000, 8'h00);  // program RAM still disabled
    send_item(OP_PPU_RD,  16'h1FFF, 8'h00);
    send_item(OP_PPU_WR,  16'h0000, 8'hFF);  // write to pattern ROM is dropped
    send_item(OP_PPU_RD,  16'h2000, 8'h00);  // high PPU address, no target
    send_item(OP_SPARE_6, 16'hFFFF, 8'hFF);
    send_item(OP_SPARE_7, 16'h8000, 8'h80);
  endtask

  // RAM control, mirroring and both bank modes through register writes.
  task automatic test_register_decode();
    send_item(OP_CPU_WR, 16'hA001, 8'h80);   // enable program RAM
    send_item(OP_CPU_WR, 16'h7FFF, 8'hFF);
    send_item(OP_CPU_RD, 16'h6000, 8'h00);
    send_item(OP_CPU_WR, 16'hA001, 8'hC0);   // enable and write protect
    send_item(OP_CPU_WR, 16'h6001, 8'h5A);   // protected write, no target
    send_item(OP_CPU_WR, 16'hA000, 8'h01);   // horizontal mirroring
    send_item(OP_CPU_WR, 16'h8000, 8'hC6);   // both mode bits, select R6
    send_item(OP_CPU_WR, 16'h8001, 8'hFF);
    send_item(OP_CPU_RD, 16'hC000, 8'h00);   // R6 now in window 2
    send_item(OP_PPU_RD, 16'h0000, 8'h00);   // swapped pattern halves
  endtask

  // Interrupt counter: zero reload fires every tick, a nonzero one counts down.
  task automatic test_scanline_irq();
    send_item(OP_CPU_WR,   16'hC000, 8'h00);
    send_item(OP_CPU_WR,   16'hE001, 8'h00);
    send_item(OP_SCANLINE, 16'h0000, 8'h00);
    send_item(OP_IRQ_CLR,  16'h0000, 8'h00);
    send_item(OP_CPU_WR,   16'hC000, 8'h01);
    send_item(OP_CPU_WR,   16'hC001, 8'h00);
    send_item(OP_SCANLINE, 16'h0000, 8'h00);
    send_item(OP_SCANLINE, 16'h0000, 8'h00);
    send_item(OP_CPU_WR,   16'hE000, 8'h00); // disable also clears the request
  endtask

  // Pattern bank past the end of a five-bank pattern RAM wraps by one subtraction.
  task automatic test_chr_wrap();
    apply_setting(9'd2, 9'd5, 1'b1);
    send_item(OP_CPU_WR, 16'h8000, 8'h00);
    send_item(OP_CPU_WR, 16'h8001, 8'h04);
    send_item(OP_PPU_RD, 16'h0400, 8'h00);
    send_item(OP_PPU_WR, 16'h07FF, 8'hA5);
  endtask

  // Random traffic across every configuration preset.
  task automatic test_bank_configs(input int items);
    int stop;
    for (int p = 0; p < PRESET_COUNT; p++) begin
      apply_preset(p);
      stop = items_sent + items / PRESET_COUNT;
      while (items_sent < stop) send_mapper_traffic();
    end
  endtask

  // Hold the output off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int k = 0; k < 40; k++) send_mapper_traffic();
  endtask

  initial begin
    reset_model();
    set_idle(34, 69);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_decode();
    test_scanline_irq();
    test_chr_wrap();

    test_bank_configs(400);
    set_idle(69, 34);
    test_bank_configs(400);
    set_idle(0, 0);
    test_backpressure();
    test_bank_configs(400);

    settle();
    $display("covered %0d bus transactions, %0d checked results, %0d register settings",
             items_sent, results_checked, settings_applied);
    $display("stalls on both sides, a %0d-cycle output hold-off and a run with no idling",
             HOLD_OFF_CYCLES);
    if (mismatch_count == 0 && expected_bus_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_bus_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bsm_pkg.sv
hdl/bsm_ctrl.sv
hdl/bsm_datapath.sv
hdl/bank_switch_mapper_with_scanline_irq_unit.sv
tb/sv/tb_bank_switch_mapper_with_scanline_irq_unit.sv
